// ----- src/qvr_pkg.sv -----
// Package for the quaternion vector rotator: widths, payload structs, codes.
// Used by every module under src; depends on nothing.
`default_nettype none
package qvr_pkg;

	localparam int DW            = 16;          // vector and quaternion component width
	localparam int FRAC_BITS_DEF = 14;          // quaternion fraction bits
	localparam int PW            = 2 * DW;      // product of two components
	localparam int MW            = 2 * DW + 3;  // rotation matrix coefficient, signed
	localparam int NW            = 2 * DW + 2;  // squared norm, unsigned
	localparam int TW            = 3 * DW + 3;  // vector times coefficient, signed
	localparam int SW            = 3 * DW + 5;  // numerator sum, signed
	localparam int AW            = 3 * DW + 6;  // dividend 2|num| + n, unsigned
	localparam int DDW           = 2 * DW + 3;  // divisor 2n, unsigned
	localparam int QW            = DW + 1;      // quotient bits kept

	typedef enum logic [1:0] {
		REG_S = 2'd0,
		REG_X = 2'd1,
		REG_Y = 2'd2,
		REG_Z = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef logic signed [MW-1:0] mcoef_t;

	typedef struct packed {
		logic signed [DW-1:0] s;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [DW-1:0] vec_x;
		logic signed [DW-1:0] vec_y;
		logic signed [DW-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [DW-1:0] rot_x;
		logic signed [DW-1:0] rot_y;
		logic signed [DW-1:0] rot_z;
		status_t              status;
	} rot_t;

	// sideband that rides with the divider lanes
	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} side_t;

endpackage
`default_nettype wire

// ----- src/qvr_coef.sv -----
// Rotation matrix stages: quaternion products, then matrix coefficients and norm.
// Depends on qvr_pkg.
`default_nettype none
module qvr_coef (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire qvr_pkg::vec_t    vec,
	input  wire qvr_pkg::quat_t   quat,
	output logic                  valid_s2,
	output qvr_pkg::vec_t         u_s2,
	output qvr_pkg::mcoef_t       m_s2 [0:2][0:2],
	output logic [qvr_pkg::NW-1:0] n_s2
);
	localparam int PW = qvr_pkg::PW;
	localparam int MW = qvr_pkg::MW;
	localparam int NW = qvr_pkg::NW;

	logic                 valid_s1;
	qvr_pkg::vec_t        u_s1;
	logic signed [PW-1:0] ss_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, xz_s1, yz_s1, sx_s1, sy_s1, sz_s1;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: pairwise quaternion products
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= vec;
			ss_s1 <= PW'(quat.s) * PW'(quat.s);
			xx_s1 <= PW'(quat.x) * PW'(quat.x);
			yy_s1 <= PW'(quat.y) * PW'(quat.y);
			zz_s1 <= PW'(quat.z) * PW'(quat.z);
			xy_s1 <= PW'(quat.x) * PW'(quat.y);
			xz_s1 <= PW'(quat.x) * PW'(quat.z);
			yz_s1 <= PW'(quat.y) * PW'(quat.z);
			sx_s1 <= PW'(quat.s) * PW'(quat.x);
			sy_s1 <= PW'(quat.s) * PW'(quat.y);
			sz_s1 <= PW'(quat.s) * PW'(quat.z);
		end
	end

	// stage 2: matrix rows (row i, column c multiplies component c)
	always_ff @(posedge clk) begin
		if (en) begin
			u_s2 <= u_s1;
			n_s2 <= NW'(MW'(ss_s1) + MW'(xx_s1) + MW'(yy_s1) + MW'(zz_s1));
			m_s2[0][0] <= MW'(ss_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			m_s2[0][1] <= (MW'(xy_s1) - MW'(sz_s1)) <<< 1;
			m_s2[0][2] <= (MW'(xz_s1) + MW'(sy_s1)) <<< 1;
			m_s2[1][0] <= (MW'(xy_s1) + MW'(sz_s1)) <<< 1;
			m_s2[1][1] <= MW'(ss_s1) + MW'(yy_s1) - MW'(zz_s1) - MW'(xx_s1);
			m_s2[1][2] <= (MW'(yz_s1) - MW'(sx_s1)) <<< 1;
			m_s2[2][0] <= (MW'(xz_s1) - MW'(sy_s1)) <<< 1;
			m_s2[2][1] <= (MW'(yz_s1) + MW'(sx_s1)) <<< 1;
			m_s2[2][2] <= MW'(ss_s1) + MW'(zz_s1) - MW'(xx_s1) - MW'(yy_s1);
		end
	end

endmodule
`default_nettype wire

// ----- src/qvr_mac.sv -----
// Numerator stages: vector times matrix, row sums, magnitude and rounding offset.
// Depends on qvr_pkg.
`default_nettype none
module qvr_mac (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_in,
	input  wire qvr_pkg::vec_t        u,
	input  wire qvr_pkg::mcoef_t      m [0:2][0:2],
	input  wire logic [qvr_pkg::NW-1:0] n,
	output logic                      valid_s5,
	output logic [qvr_pkg::AW-1:0]    a_s5 [0:2],
	output logic [qvr_pkg::DDW-1:0]   d_s5,
	output qvr_pkg::side_t            side_s5
);
	localparam int DW  = qvr_pkg::DW;
	localparam int NW  = qvr_pkg::NW;
	localparam int TW  = qvr_pkg::TW;
	localparam int SW  = qvr_pkg::SW;
	localparam int AW  = qvr_pkg::AW;
	localparam int DDW = qvr_pkg::DDW;

	logic                 valid_s3, valid_s4;
	logic signed [TW-1:0] t_s3 [0:2][0:2];
	logic signed [SW-1:0] sum_s4 [0:2];
	logic [NW-1:0]        n_s3, n_s4;
	logic signed [DW-1:0] uc [0:2];
	logic [SW-1:0]        mag [0:2];

	assign uc[0] = u.vec_x;
	assign uc[1] = u.vec_y;
	assign uc[2] = u.vec_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = sum_s4[i][SW-1] ? SW'(-sum_s4[i]) : sum_s4[i];
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 3 products, stage 4 row sums, stage 5 dividend and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= n;
			n_s4 <= n_s3;
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					t_s3[i][c] <= TW'(uc[c]) * TW'(m[i][c]);
				end
				sum_s4[i] <= SW'(t_s3[i][0]) + SW'(t_s3[i][1]) + SW'(t_s3[i][2]);
				side_s5.neg[i] <= sum_s4[i][SW-1];
				a_s5[i] <= AW'({mag[i], 1'b0}) + AW'(n_s4);
			end
			d_s5         <= DDW'({n_s4, 1'b0});
			side_s5.zero <= (n_s4 == '0);
		end
	end

endmodule
`default_nettype wire

// ----- src/qvr_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on qvr_pkg.
`default_nettype none
module qvr_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_in,
	input  wire logic [qvr_pkg::AW-1:0] a [0:2],
	input  wire logic [qvr_pkg::DDW-1:0] d,
	input  wire qvr_pkg::side_t       side,
	output logic                      valid_out,
	output logic [qvr_pkg::QW-1:0]    quo [0:2],
	output logic [2:0]                ovf,
	output qvr_pkg::side_t            side_out
);
	localparam int AW  = qvr_pkg::AW;
	localparam int DDW = qvr_pkg::DDW;
	localparam int QW  = qvr_pkg::QW;

	logic                 val_s  [0:QW];
	logic [AW-1:0]        rem_s  [0:QW][0:2];
	logic [QW-1:0]        quo_s  [0:QW][0:2];
	logic [2:0]           ovf_s  [0:QW];
	logic [DDW-1:0]       den_s  [0:QW];
	qvr_pkg::side_t       side_s [0:QW];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				val_s[k] <= 1'b0;
			end
		end else if (en) begin
			val_s[0] <= valid_in;
			for (int k = 1; k <= QW; k++) begin
				val_s[k] <= val_s[k-1];
			end
		end
	end

	// entry stage: flag quotients too large to keep
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= d;
			side_s[0] <= side;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= a[i];
				quo_s[0][i] <= '0;
				ovf_s[0][i] <= (a[i] >= (AW'(d) << QW));
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [AW-1:0] sub;
		assign sub = AW'(den_s[k]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				for (int i = 0; i < 3; i++) begin
					if (rem_s[k][i] >= sub) begin
						rem_s[k+1][i] <= rem_s[k][i] - sub;
						quo_s[k+1][i] <= quo_s[k][i] | (QW'(1) << B);
					end else begin
						rem_s[k+1][i] <= rem_s[k][i];
						quo_s[k+1][i] <= quo_s[k][i];
					end
				end
			end
		end
	end

	assign valid_out = val_s[QW];
	assign quo       = quo_s[QW];
	assign ovf       = ovf_s[QW];
	assign side_out  = side_s[QW];

endmodule
`default_nettype wire

// ----- src/quaternion_vector_rotate.sv -----
// Throughput: one vector per cycle while no result is held at the output by out_stall;
// the divider takes one quotient bit per stage (DW + 2 stages, with its entry stage),
// behind two matrix and three numerator stages.
// A stall at the output freezes the whole pipeline at once; nothing is lost or repeated.
// Reset (arst_n, asynchronous) clears all valid bits and sets the identity quaternion.
`default_nettype none
module quaternion_vector_rotate #(
	parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire qvr_pkg::reg_idx_t   cfg_index,
	input  wire logic [qvr_pkg::DW-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire qvr_pkg::vec_t       in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output qvr_pkg::rot_t            out_data
);
	localparam int DW  = qvr_pkg::DW;
	localparam int NW  = qvr_pkg::NW;
	localparam int AW  = qvr_pkg::AW;
	localparam int DDW = qvr_pkg::DDW;
	localparam int QW  = qvr_pkg::QW;
	localparam logic [QW-1:0] HALF = QW'(1) << (DW - 1);

	qvr_pkg::quat_t  quat_q;
	logic            en;
	logic            valid_s2, valid_s5, valid_dv;
	qvr_pkg::vec_t   u_s2;
	qvr_pkg::mcoef_t m_s2 [0:2][0:2];
	logic [NW-1:0]   n_s2;
	logic [AW-1:0]   a_s5 [0:2];
	logic [DDW-1:0]  d_s5;
	qvr_pkg::side_t  side_s5, side_dv;
	logic [QW-1:0]   quo_dv [0:2];
	logic [2:0]      ovf_dv;
	logic            out_valid_q;
	qvr_pkg::rot_t   out_q;
	logic [DW-1:0]   res [0:2];
	logic [2:0]      sat;

	// whole pipeline moves unless a result is held at the output
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// quaternion registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.s <= DW'(64'd1 << FRAC_BITS);
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qvr_pkg::REG_S: quat_q.s <= cfg_data;
				qvr_pkg::REG_X: quat_q.x <= cfg_data;
				qvr_pkg::REG_Y: quat_q.y <= cfg_data;
				qvr_pkg::REG_Z: quat_q.z <= cfg_data;
			endcase
		end
	end

	qvr_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.vec      (in_data),
		.quat     (quat_q),
		.valid_s2 (valid_s2),
		.u_s2     (u_s2),
		.m_s2     (m_s2),
		.n_s2     (n_s2)
	);

	qvr_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (valid_s2),
		.u        (u_s2),
		.m        (m_s2),
		.n        (n_s2),
		.valid_s5 (valid_s5),
		.a_s5     (a_s5),
		.d_s5     (d_s5),
		.side_s5  (side_s5)
	);

	qvr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s5),
		.a         (a_s5),
		.d         (d_s5),
		.side      (side_s5),
		.valid_out (valid_dv),
		.quo       (quo_dv),
		.ovf       (ovf_dv),
		.side_out  (side_dv)
	);

	// apply sign and clamp each component
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_dv.neg[i]) begin
				sat[i] = ovf_dv[i] || (quo_dv[i] > HALF);
				res[i] = sat[i] ? HALF[DW-1:0] : DW'(-quo_dv[i]);
			end else begin
				sat[i] = ovf_dv[i] || (quo_dv[i] >= HALF);
				res[i] = sat[i] ? DW'(HALF - QW'(1)) : quo_dv[i][DW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_dv.zero) begin
				out_q.rot_x  <= '0;
				out_q.rot_y  <= '0;
				out_q.rot_z  <= '0;
				out_q.status <= qvr_pkg::ST_ZERO;
			end else begin
				out_q.rot_x  <= res[0];
				out_q.rot_y  <= res[1];
				out_q.rot_z  <= res[2];
				out_q.status <= (sat != 3'b000) ? qvr_pkg::ST_SAT : qvr_pkg::ST_OK;
			end
		end
	end

`ifndef SYNTHESIS
	// a zero quaternion yields a zero vector
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == qvr_pkg::ST_ZERO |->
		out_data.rot_x == '0 && out_data.rot_y == '0 && out_data.rot_z == '0)
		else $error("zero quaternion result not cleared");

	// input is held off exactly while a result waits
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall out of step with output");

	// the identity rotation never saturates
	a_identity_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quat_q.s == DW'(64'd1 << FRAC_BITS) && quat_q.x == '0 &&
		quat_q.y == '0 && quat_q.z == '0 |-> out_data.status == qvr_pkg::ST_OK)
		else $error("identity rotation flagged");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for quaternion_vector_rotate: random and directed vectors under several quaternions.
// Expected results come from a scoreboard class with its own integer predictor.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW           = qvr_pkg::DW;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 5000;

	// scoreboard: holds the quaternion copy and the queue of predicted rotations
	class rotation_board;
		longint        quat[4];
		qvr_pkg::rot_t pending_rot[$];
		int            mismatches;

		function new();
			quat[qvr_pkg::REG_S] = 16384;
			quat[qvr_pkg::REG_X] = 0;
			quat[qvr_pkg::REG_Y] = 0;
			quat[qvr_pkg::REG_Z] = 0;
			mismatches  = 0;
		endfunction

		function void set_reg(qvr_pkg::reg_idx_t idx, logic signed [DW-1:0] val);
			quat[idx] = longint'(val);
		endfunction

		// predict the rotated vector for one accepted request
		function void note(qvr_pkg::vec_t req);
			longint u[3];
			longint s, n, num, mag, quo;
			qvr_pkg::rot_t exp_rot;
			logic signed [DW-1:0] comp[3];
			int     j, k;
			u[0] = longint'(req.vec_x);
			u[1] = longint'(req.vec_y);
			u[2] = longint'(req.vec_z);
			s = quat[qvr_pkg::REG_S];
			n = s * s + quat[1] * quat[1] + quat[2] * quat[2] + quat[3] * quat[3];
			exp_rot.status = qvr_pkg::ST_OK;
			if (n == 0) begin
				comp = '{0, 0, 0};
				exp_rot.status = qvr_pkg::ST_ZERO;
			end else begin
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					k = (i + 2) % 3;
					num = u[i] * (s * s + quat[i+1] * quat[i+1] - quat[j+1] * quat[j+1]
						- quat[k+1] * quat[k+1])
						+ 2 * u[j] * (quat[i+1] * quat[j+1] - s * quat[k+1])
						+ 2 * u[k] * (quat[i+1] * quat[k+1] + s * quat[j+1]);
					mag = num < 0 ? -num : num;
					// round half away from zero
					quo = (2 * mag + n) / (2 * n);
					if (num < 0) begin
						if (quo > 32768) begin
							comp[i] = 16'sh8000;
							exp_rot.status = qvr_pkg::ST_SAT;
						end else begin
							comp[i] = DW'(-quo);
						end
					end else begin
						if (quo > 32767) begin
							comp[i] = 16'sh7fff;
							exp_rot.status = qvr_pkg::ST_SAT;
						end else begin
							comp[i] = DW'(quo);
						end
					end
				end
			end
			exp_rot.rot_x = comp[0];
			exp_rot.rot_y = comp[1];
			exp_rot.rot_z = comp[2];
			pending_rot.push_back(exp_rot);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check(qvr_pkg::rot_t got);
			qvr_pkg::rot_t want;
			if (pending_rot.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = pending_rot.pop_front();
				if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
					got.rot_z !== want.rot_z || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
							want.rot_x, want.rot_y, want.rot_z, want.status,
							got.rot_x, got.rot_y, got.rot_z, got.status);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	qvr_pkg::reg_idx_t cfg_index = qvr_pkg::REG_S;
	logic [DW-1:0]     cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	qvr_pkg::vec_t     in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	qvr_pkg::rot_t     out_data;

	rotation_board board = new();
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	quaternion_vector_rotate uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// observe both handshakes and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note(in_data);
			if (out_valid && !out_stall)
				board.check(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver stall pattern: solid stalls, random stalls and quiet stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(1, 20);
			stall_mode = $urandom_range(0, 3);
		end
		stall_left = stall_left - 1;
		out_stall <= (stall_mode == 0) ? 1'b1 :
			(stall_mode == 1) ? ($urandom_range(0, 2) == 0) : 1'b0;
	end

	// present one register write; the caller drops the enable after the last one
	task automatic write_reg(input qvr_pkg::reg_idx_t idx, input logic [DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic load_quat(input logic [DW-1:0] s, x, y, z);
		write_reg(qvr_pkg::REG_S, s);
		write_reg(qvr_pkg::REG_X, x);
		write_reg(qvr_pkg::REG_Y, y);
		write_reg(qvr_pkg::REG_Z, z);
		cfg_we <= 1'b0;
	endtask

	// present one request, keeping valid high within a burst
	task automatic send_vec(input qvr_pkg::vec_t v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_data  <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// drop valid, then wait for every predicted result and DRAIN_CYCLES more
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.pending_rot.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					3: return 16'h0001;
					default: return 16'h0000;
				endcase
			end
			1: return DW'($urandom_range(0, 64)) - 16'd32;
			default: return DW'($urandom());
		endcase
	endfunction

	task automatic random_vecs(input int count);
		for (int i = 0; i < count; i++)
			send_vec('{vec_x: pick_value(), vec_y: pick_value(), vec_z: pick_value()});
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: extremes pass straight through
		send_vec('{vec_x: 16'h0000, vec_y: 16'h0000, vec_z: 16'h0000});
		send_vec('{vec_x: 16'h7fff, vec_y: 16'h8000, vec_z: 16'hffff});
		send_vec('{vec_x: 16'h8000, vec_y: 16'h7fff, vec_z: 16'h0001});
		send_vec('{vec_x: 16'h1234, vec_y: 16'hedcb, vec_z: 16'h5555});
		drain();

		// quarter turn about z, with vectors that round and saturate
		load_quat(16'd11585, 16'd0, 16'd0, 16'd11585);
		send_vec('{vec_x: 16'h7fff, vec_y: 16'h8000, vec_z: 16'h0000});
		send_vec('{vec_x: 16'h8000, vec_y: 16'h8000, vec_z: 16'h8000});
		send_vec('{vec_x: 16'h0001, vec_y: 16'h0003, vec_z: 16'hffff});
		send_vec('{vec_x: 16'h7fff, vec_y: 16'h7fff, vec_z: 16'h7fff});
		drain();

		// zero quaternion
		load_quat(16'd0, 16'd0, 16'd0, 16'd0);
		send_vec('{vec_x: 16'h7fff, vec_y: 16'h8000, vec_z: 16'h0001});
		send_vec('{vec_x: 16'h0000, vec_y: 16'h0000, vec_z: 16'h0000});
		random_vecs(40);
		drain();

		// register extremes
		load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_vec('{vec_x: 16'h7fff, vec_y: 16'h8000, vec_z: 16'h0001});
		random_vecs(60);
		drain();
		load_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_vec('{vec_x: 16'h8000, vec_y: 16'h7fff, vec_z: 16'hffff});
		random_vecs(60);
		drain();
		load_quat(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
		random_vecs(60);
		drain();
		load_quat(16'h0001, 16'h0000, 16'hffff, 16'h0000);
		random_vecs(60);
		drain();

		// random quaternions, full range and a narrower range (s 0 to 16384, others within 10000)
		for (int p = 0; p < 10; p++) begin
			if (p % 2 == 0)
				load_quat(DW'($urandom()), DW'($urandom()), DW'($urandom()), DW'($urandom()));
			else
				load_quat(DW'($urandom_range(0, 16384)), DW'($urandom_range(0, 20000)) - 16'd10000,
					DW'($urandom_range(0, 20000)) - 16'd10000,
					DW'($urandom_range(0, 20000)) - 16'd10000);
			random_vecs(85);
			drain();
		end

		if (board.pending_rot.size() != 0)
			board.mismatches++;
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
